// File: rtl/core/fps_pkg.sv
// ----------------------------------------------------------------------------
// fps_pkg
// Shared types and constants of the binary indexed prefix-sum tree: payload
// structs, command codes and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package fps_pkg;

    // field widths
    localparam int CMD_W  = 2;
    localparam int POS_W  = 10;
    localparam int CNT_W  = 11;
    localparam int DATA_W = 64;
    // one-based walk index, wide enough for the step past the last node
    localparam int KIDX_W = 12;

    // command codes
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PREFIX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd2;

    // walk index load selects
    localparam logic [1:0] KSEL_POS_PLUS1 = 2'd0;
    localparam logic [1:0] KSEL_RANGE_END = 2'd1;
    localparam logic [1:0] KSEL_POS       = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [POS_W-1:0]  position;
        logic [DATA_W-1:0] delta;
        logic [CNT_W-1:0]  span_length;
    } fps_in_t;

    typedef struct packed {
        logic [DATA_W-1:0] sum_value;
        logic              status;
    } fps_out_t;

    // controller to datapath
    typedef struct packed {
        logic       load_item;
        logic       clr_acc;
        logic       load_k;
        logic [1:0] k_sel;
        logic       walk;
        logic       up;
        logic       sub;
        logic       clr_wr;
        logic       load_out;
    } fps_ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic             err;
        logic [CMD_W-1:0] command;
        logic             span_zero;
        logic             up_end;
        logic             down_end;
        logic             clr_last;
    } fps_stat_t;

endpackage

// File: rtl/core/fps_ctrl.sv
// ----------------------------------------------------------------------------
// fps_ctrl
// Sequencer of the prefix-sum tree: clearing pass after reset, command
// dispatch, upward and downward tree walks, and the result handshake.
// ----------------------------------------------------------------------------
module fps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  fps_pkg::fps_stat_t stat,
    output fps_pkg::fps_ctrl_t ctrl
);
    import fps_pkg::*;

    localparam logic [2:0] ST_CLEAR    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_START    = 3'd2;
    localparam logic [2:0] ST_UP       = 3'd3;
    localparam logic [2:0] ST_DOWN_ADD = 3'd4;
    localparam logic [2:0] ST_DOWN_SUB = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                ctrl.clr_wr = 1'b1;
                if (stat.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready        = 1'b1;
                ctrl.load_item = s_valid;
                if (s_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                ctrl.clr_acc = 1'b1;
                if (stat.err) begin
                    state_next = ST_DONE;
                end else if (stat.command == CMD_UPDATE) begin
                    ctrl.load_k = 1'b1;
                    ctrl.k_sel  = KSEL_POS_PLUS1;
                    state_next  = ST_UP;
                end else if (stat.command == CMD_PREFIX) begin
                    ctrl.load_k = 1'b1;
                    ctrl.k_sel  = KSEL_POS_PLUS1;
                    state_next  = ST_DOWN_ADD;
                end else if (stat.span_zero) begin
                    state_next = ST_DONE;
                end else begin
                    ctrl.load_k = 1'b1;
                    ctrl.k_sel  = KSEL_RANGE_END;
                    state_next  = ST_DOWN_ADD;
                end
            end
            ST_UP: begin
                ctrl.up = 1'b1;
                if (stat.up_end) begin
                    state_next = ST_DONE;
                end else begin
                    ctrl.walk = 1'b1;
                end
            end
            ST_DOWN_ADD: begin
                if (!stat.down_end) begin
                    ctrl.walk = 1'b1;
                end else if (stat.command == CMD_RANGE) begin
                    ctrl.load_k = 1'b1;
                    ctrl.k_sel  = KSEL_POS;
                    state_next  = ST_DOWN_SUB;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DOWN_SUB: begin
                ctrl.sub = 1'b1;
                if (stat.down_end) begin
                    state_next = ST_DONE;
                end else begin
                    ctrl.walk = 1'b1;
                end
            end
            ST_DONE: begin
                if (!out_valid_reg || m_ready) begin
                    ctrl.load_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result beat valid
    always_comb begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_valid = out_valid_reg;

    // result register is only overwritten once its beat is gone
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> (!out_valid_reg || m_ready))
        else $error("result overwritten while still waiting");

    // clearing pass runs to its last entry
    a_clear_runs: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !stat.clr_last) |=> state_reg == ST_CLEAR)
        else $error("clearing pass left early");

    // memory reads only inside a walk
    a_walk_states: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.walk |-> (state_reg == ST_UP || state_reg == ST_DOWN_ADD ||
                       state_reg == ST_DOWN_SUB))
        else $error("walk step outside a walk state");

    // an accepted beat starts dispatch
    a_accept_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == ST_START)
        else $error("accepted beat not dispatched");

endmodule

// File: rtl/core/fps_datapath.sv
// ----------------------------------------------------------------------------
// fps_datapath
// Tree store, walk index, read/modify/write pipe, accumulator, range checks,
// size register and result register of the prefix-sum tree.
// ----------------------------------------------------------------------------
module fps_datapath #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [fps_pkg::CNT_W-1:0] cfg_wr_data,
    input  fps_pkg::fps_in_t          in_data,
    input  fps_pkg::fps_ctrl_t        ctrl,
    output fps_pkg::fps_stat_t        stat,
    output fps_pkg::fps_out_t         out_data
);
    import fps_pkg::*;

    localparam int AW            = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RESET_ENTRIES = (MAX_ENTRIES < 1024) ? MAX_ENTRIES : 1024;

    logic [CNT_W-1:0]  entries_reg;
    logic [CMD_W-1:0]  cmd_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [DATA_W-1:0] delta_reg;
    logic [CNT_W-1:0]  span_reg;
    logic              err_reg;
    logic              err_next;
    logic [KIDX_W-1:0] k_reg, k_next, k_low;
    logic [AW-1:0]     rd_addr;
    logic [DATA_W-1:0] rd_data_reg;
    logic              pend_reg;
    logic [AW-1:0]     pend_addr_reg;
    logic              pend_up_reg;
    logic              pend_sub_reg;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [AW-1:0]     clr_addr_reg;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic [KIDX_W-1:0] range_end;
    logic              bad_cmd, pos_bad, range_bad;
    fps_out_t          out_reg;

    logic [DATA_W-1:0] store_mem [MAX_ENTRIES];

    // size register, saturated to the store depth
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= CNT_W'(RESET_ENTRIES);
        end else if (cfg_wr_en) begin
            if (32'(cfg_wr_data) > 32'(MAX_ENTRIES)) begin
                entries_reg <= CNT_W'(MAX_ENTRIES);
            end else begin
                entries_reg <= cfg_wr_data;
            end
        end
    end

    // bounds checks on the incoming beat
    always_comb begin
        range_end = KIDX_W'(in_data.position) + KIDX_W'(in_data.span_length);
        bad_cmd   = (in_data.command != CMD_UPDATE) && (in_data.command != CMD_PREFIX) &&
                    (in_data.command != CMD_RANGE);
        pos_bad   = CNT_W'(in_data.position) >= entries_reg;
        range_bad = (in_data.command == CMD_RANGE) && (range_end > KIDX_W'(entries_reg));
        err_next  = bad_cmd || pos_bad || range_bad;
    end

    // item registers
    always_ff @(posedge aclk) begin
        if (ctrl.load_item) begin
            cmd_reg   <= in_data.command;
            pos_reg   <= in_data.position;
            delta_reg <= in_data.delta;
            span_reg  <= in_data.span_length;
            err_reg   <= err_next;
        end
    end

    // walk index: up adds the lowest set bit, down clears it
    assign k_low = k_reg & (~k_reg + KIDX_W'(1));

    always_comb begin
        k_next = k_reg;
        if (ctrl.load_k) begin
            unique case (ctrl.k_sel)
                KSEL_POS_PLUS1: k_next = KIDX_W'(pos_reg) + KIDX_W'(1);
                KSEL_RANGE_END: k_next = KIDX_W'(pos_reg) + KIDX_W'(span_reg);
                KSEL_POS:       k_next = KIDX_W'(pos_reg);
                default:        k_next = '0;
            endcase
        end else if (ctrl.walk) begin
            k_next = ctrl.up ? (k_reg + k_low) : (k_reg & (k_reg - KIDX_W'(1)));
        end
    end

    always_ff @(posedge aclk) begin
        k_reg <= k_next;
    end

    assign rd_addr = AW'(k_reg - KIDX_W'(1));

    // write port: clearing pass or update write-back
    always_comb begin
        wr_en   = ctrl.clr_wr || (pend_reg && pend_up_reg);
        wr_addr = ctrl.clr_wr ? clr_addr_reg : pend_addr_reg;
        wr_data = ctrl.clr_wr ? '0 : (rd_data_reg + delta_reg);
    end

    // tree store, registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= wr_data;
        end
        if (ctrl.walk) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    // read in flight, finished in the cycle after issue
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= ctrl.walk;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.walk) begin
            pend_addr_reg <= rd_addr;
            pend_up_reg   <= ctrl.up;
            pend_sub_reg  <= ctrl.sub;
        end
    end

    // clearing pass address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (ctrl.clr_wr) begin
            clr_addr_reg <= AW'(clr_addr_reg + AW'(1));
        end
    end

    // accumulator for the downward walks
    always_comb begin
        acc_next = acc_reg;
        if (ctrl.clr_acc) begin
            acc_next = '0;
        end else if (pend_reg && !pend_up_reg) begin
            acc_next = pend_sub_reg ? (acc_reg - rd_data_reg) : (acc_reg + rd_data_reg);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    // result register
    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            out_reg.sum_value <= acc_reg;
            out_reg.status    <= err_reg;
        end
    end

    assign out_data = out_reg;

    // status to the controller
    always_comb begin
        stat.err       = err_reg;
        stat.command   = cmd_reg;
        stat.span_zero = (span_reg == '0);
        stat.up_end    = k_reg > KIDX_W'(entries_reg);
        stat.down_end  = (k_reg == '0);
        stat.clr_last  = (clr_addr_reg == AW'(MAX_ENTRIES - 1));
    end

endmodule

// File: rtl/core/fenwick_prefix_sum_tree_top.sv
// ----------------------------------------------------------------------------
// fenwick_prefix_sum_tree_top
// Binary indexed tree of 64-bit counts with update, prefix and range queries.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel takes one command beat (update, prefix sum, range sum); m_*
//   channel returns exactly one result beat per command: the sum modulo 2^64
//   and a status bit (1 when the position or range lies beyond the size
//   register, or the command code is unknown; the store is then untouched).
//   cfg_wr_en/cfg_wr_data set the number of positions in use; write it only
//   while no command is in flight.
//   Sequence: each command passes a dispatch state, one tree walk (two for
//   a range), and a done state that loads the result register. The tree
//   walk sets the run time: at most 11 nodes for an update, up to 10 for a
//   prefix and up to 19 over two walks for a range; a flagged command and an
//   empty range skip the walks. The store is a single memory with one read
//   and one write port, so one node is visited per cycle. After reset the
//   store is cleared one word a cycle, through all MAX_ENTRIES words, with
//   s_ready low. A new command is accepted while a result beat still
//   waits for m_ready; a stalled result holds its command in the done state.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_tree_top #(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [fps_pkg::CNT_W-1:0] cfg_wr_data,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  fps_pkg::fps_in_t          s_data,
    output logic                      m_valid,
    input  logic                      m_ready,
    output fps_pkg::fps_out_t         m_data
);
    import fps_pkg::*;

    fps_ctrl_t ctrl;
    fps_stat_t stat;

    // sequencer
    fps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .ctrl    (ctrl)
    );

    // store and arithmetic
    fps_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (s_data),
        .ctrl        (ctrl),
        .stat        (stat),
        .out_data    (m_data)
    );

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the binary indexed prefix-sum tree end to end. Command beats are
// driven on the s_ channel under random sender gaps. Each accepted beat is
// run through a local copy of the tree to predict its result beat. Result
// beats leave on the m_ channel under random back-pressure and are compared
// field by field, in order, against the predictions. The size register is
// stepped through zero, one, small, full and saturating values.
// ----------------------------------------------------------------------------
module tb;
    import fps_pkg::*;

    localparam int TREE_DEPTH   = 1024;
    localparam int SIZE_MAX_REG = 2047;
    localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]  cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    fps_in_t           s_data = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    fps_out_t          m_data;

    // local copy of the tree and its size register
    logic [DATA_W-1:0] node_sums [TREE_DEPTH];
    int unsigned       covered_positions;

    fps_out_t          pending_results [$];
    int                mismatch_count = 0;
    int                send_gap_pct = 0;
    int                ready_gap_pct = 0;

    fenwick_prefix_sum_tree_top #(
        .MAX_ENTRIES(TREE_DEPTH)
    ) uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // clock
    always #5 aclk = ~aclk;

    // sum of the first count positions, walking down by clearing the low bit
    function automatic logic [DATA_W-1:0] prefix_total(input int unsigned count);
        logic [DATA_W-1:0] acc;
        int unsigned       k;
        acc = '0;
        k = count;
        while (k != 0) begin
            if (k <= TREE_DEPTH) acc += node_sums[k-1];
            k = k & (k - 1);
        end
        return acc;
    endfunction

    // add at one position, walking up by adding the low bit
    function automatic void add_at(input int unsigned pos, input logic [DATA_W-1:0] amount);
        int unsigned k;
        k = pos + 1;
        while (k != 0 && k <= covered_positions) begin
            node_sums[k-1] += amount;
            k = k + (k & (~k + 1));
        end
    endfunction

    // expected result beat of one command; updates the local tree
    function automatic fps_out_t fenwick_result(input fps_in_t beat);
        fps_out_t    res;
        int unsigned pos;
        int unsigned span;
        res = '0;
        pos = beat.position;
        span = beat.span_length;
        if (beat.command == CMD_UNKNOWN || pos >= covered_positions) begin
            res.status = 1'b1;
        end else begin
            case (beat.command)
                CMD_UPDATE: add_at(pos, beat.delta);
                CMD_PREFIX: res.sum_value = prefix_total(pos + 1);
                CMD_RANGE: begin
                    if (pos + span > covered_positions)
                        res.status = 1'b1;
                    else if (span != 0)
                        res.sum_value = prefix_total(pos + span) - prefix_total(pos);
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic fps_in_t make_item(input logic [CMD_W-1:0] cmd, input int unsigned pos,
                                          input logic [DATA_W-1:0] amount,
                                          input int unsigned span);
        fps_in_t item;
        item.command = cmd;
        item.position = POS_W'(pos);
        item.delta = amount;
        item.span_length = CNT_W'(span);
        return item;
    endfunction

    // send one command beat; entered and left at a falling edge
    task automatic send_command(input fps_in_t item);
        while ($urandom_range(99) < send_gap_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = item;
        do @(posedge aclk); while (!s_ready);
        pending_results.insert(pending_results.size(), fenwick_result(item));
        @(negedge aclk);
    endtask

    // drop valid and wait until every result beat is back and the block is ready
    task automatic wait_idle();
        s_valid = 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0 || !s_ready);
        @(negedge aclk);
    endtask

    // write the size register while idle
    task automatic write_size(input int unsigned value);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_wr_data = CNT_W'(value);
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        covered_positions = (value > TREE_DEPTH) ? TREE_DEPTH : value;
    endtask

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= ready_gap_pct);
    end

    // result checker
    always @(posedge aclk) begin
        fps_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: sum_value %h status %0d",
                       m_data.sum_value, m_data.status);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_data.sum_value !== want.sum_value) begin
                    $error("sum_value: expected %h, actual %h",
                           want.sum_value, m_data.sum_value);
                    mismatch_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_data.status);
                    mismatch_count++;
                end
            end
        end
    end

    // cleared store after reset, full size
    task automatic test_reset_state();
        wait_idle();
        send_command(make_item(CMD_PREFIX, TREE_DEPTH - 1, '0, 0));
        send_command(make_item(CMD_RANGE, 0, '1, TREE_DEPTH));
    endtask

    // field extremes, wrap, empty and overlong ranges, unknown command
    task automatic test_field_extremes();
        send_command(make_item(CMD_UPDATE, 0, '1, SIZE_MAX_REG));
        send_command(make_item(CMD_UPDATE, TREE_DEPTH - 1, '1, 0));
        send_command(make_item(CMD_UPDATE, 511, 64'd2, 0));
        send_command(make_item(CMD_PREFIX, 0, '0, 0));
        send_command(make_item(CMD_PREFIX, TREE_DEPTH - 1, '0, SIZE_MAX_REG));
        send_command(make_item(CMD_RANGE, 0, '0, TREE_DEPTH));
        send_command(make_item(CMD_RANGE, TREE_DEPTH - 1, '0, 1));
        send_command(make_item(CMD_RANGE, 5, '0, 0));
        send_command(make_item(CMD_RANGE, 1000, '0, 25));
        send_command(make_item(CMD_RANGE, 0, '0, SIZE_MAX_REG));
        send_command(make_item(CMD_UNKNOWN, 0, '1, 1));
    endtask

    // size register: zero, saturation, one, and a store not rebuilt on growth
    task automatic test_size_register();
        write_size(0);
        send_command(make_item(CMD_UPDATE, 0, 64'd7, 0));
        send_command(make_item(CMD_PREFIX, 0, '0, 0));
        write_size(SIZE_MAX_REG);
        send_command(make_item(CMD_PREFIX, TREE_DEPTH - 1, '0, 0));
        write_size(1);
        send_command(make_item(CMD_UPDATE, 0, 64'd9, 0));
        send_command(make_item(CMD_PREFIX, 0, '0, 0));
        send_command(make_item(CMD_PREFIX, 1, '0, 0));
        send_command(make_item(CMD_RANGE, 0, '0, 1));
        send_command(make_item(CMD_RANGE, 0, '0, 2));
        write_size(100);
        send_command(make_item(CMD_UPDATE, 99, 64'd1000, 0));
        send_command(make_item(CMD_UPDATE, 50, 64'd33, 0));
        write_size(TREE_DEPTH);
        send_command(make_item(CMD_PREFIX, TREE_DEPTH - 1, '0, 0));
        send_command(make_item(CMD_PREFIX, 127, '0, 0));
    endtask

    // mixed traffic, mostly well-formed commands within the given size
    task automatic test_random_traffic(input int count, input int unsigned size);
        fps_in_t     item;
        int unsigned pick;
        int unsigned pos;
        write_size(size);
        repeat (count) begin
            pick = $urandom_range(99);
            item.command = (pick < 40) ? CMD_UPDATE :
                           (pick < 70) ? CMD_PREFIX :
                           (pick < 95) ? CMD_RANGE : CMD_UNKNOWN;
            if (covered_positions != 0 && $urandom_range(9) < 8)
                pos = $urandom_range(covered_positions - 1);
            else
                pos = $urandom_range(TREE_DEPTH - 1);
            item.position = POS_W'(pos);
            case ($urandom_range(2))
                0: item.delta = DATA_W'($urandom_range(1000));
                1: item.delta = {$urandom, $urandom};
                default: item.delta = '0 - DATA_W'($urandom_range(1000));
            endcase
            if (pos < covered_positions && $urandom_range(9) < 8)
                item.span_length = CNT_W'($urandom_range(covered_positions - pos));
            else
                item.span_length = CNT_W'($urandom_range(SIZE_MAX_REG));
            send_command(item);
        end
    endtask

    // main sequence
    initial begin
        foreach (node_sums[i]) node_sums[i] = '0;
        covered_positions = TREE_DEPTH;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        send_gap_pct = 35;
        ready_gap_pct = 77;
        test_reset_state();
        test_field_extremes();
        test_size_register();
        test_random_traffic(150, TREE_DEPTH);

        send_gap_pct = 77;
        ready_gap_pct = 35;
        test_random_traffic(150, $urandom_range(2, TREE_DEPTH - 1));

        send_gap_pct = 0;
        ready_gap_pct = 0;
        test_random_traffic(150, SIZE_MAX_REG);

        s_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
